@@ design/epr_pkg.sv @@
// Shared types, constants and port-choice logic for the port reservation scheduler.
package epr_pkg;

  localparam int WINDOW_CYCLES = 256;
  localparam int CYCLE_RANGE   = 512;
  localparam int LIMIT         = (WINDOW_CYCLES < CYCLE_RANGE) ? WINDOW_CYCLES : CYCLE_RANGE;
  localparam int CYC_W         = 9;
  localparam int ROW_W         = 3;
  localparam int ROWS_PER_CELL = 1 << ROW_W;
  localparam int NCELL         = (LIMIT + ROWS_PER_CELL - 1) / ROWS_PER_CELL;
  localparam int CELL_W        = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int FUNC_W        = 2;
  localparam int CLASS_W       = 3;
  localparam int PORT_W        = 2;
  localparam int BUSY_W        = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_PROBE   = 2'd0,
    FN_RESERVE = 2'd1,
    FN_CLEAR   = 2'd2,
    FN_NOP     = 2'd3
  } func_t;

  localparam logic [CLASS_W-1:0] PC_NONE = 3'd0;
  localparam logic [CLASS_W-1:0] PC_P0   = 3'd1;
  localparam logic [CLASS_W-1:0] PC_P1   = 3'd2;
  localparam logic [CLASS_W-1:0] PC_P5   = 3'd3;
  localparam logic [CLASS_W-1:0] PC_P01  = 3'd4;
  localparam logic [CLASS_W-1:0] PC_P05  = 3'd5;

  localparam logic [PORT_W-1:0] SP_NONE = 2'd0;
  localparam logic [PORT_W-1:0] SP_P0   = 2'd1;
  localparam logic [PORT_W-1:0] SP_P1   = 2'd2;
  localparam logic [PORT_W-1:0] SP_P5   = 2'd3;

  localparam logic [BUSY_W-1:0] BIT_P0 = 3'b001;
  localparam logic [BUSY_W-1:0] BIT_P1 = 3'b010;
  localparam logic [BUSY_W-1:0] BIT_P5 = 3'b100;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_QUICK
  } state_t;

  typedef struct packed {
    logic                 load;
    logic [CELL_W-1:0]    start_cell;
    logic                 go;
    logic                 commit;
    logic                 clear;
    logic [ROW_W-1:0]     lo;
    logic [CLASS_W-1:0]   first;
    logic [PORT_W-1:0]    second;
  } cell_req_t;

  typedef struct packed {
    logic             hit;
    logic [CYC_W-1:0] cycle;
  } cell_res_t;

  function automatic logic [BUSY_W-1:0] port_bit(input logic [PORT_W-1:0] p);
    logic [BUSY_W-1:0] b;
    case (p)
      SP_P0:   b = BIT_P0;
      SP_P1:   b = BIT_P1;
      SP_P5:   b = BIT_P5;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [BUSY_W-1:0] row_pick(input logic [BUSY_W-1:0]  busy,
                                                 input logic [CLASS_W-1:0] first,
                                                 input logic [PORT_W-1:0]  second);
    logic [BUSY_W-1:0] need;
    logic [BUSY_W-1:0] take;
    need = port_bit(first[PORT_W-1:0]) | port_bit(second);
    take = '0;
    case (first)
      PC_NONE: take = '0;
      PC_P0, PC_P1, PC_P5: take = ((busy & need) != '0) ? '0 : need;
      PC_P01: begin
        if (!busy[0])      take = BIT_P0;
        else if (!busy[1]) take = BIT_P1;
      end
      PC_P05: begin
        if (!busy[2])      take = BIT_P5;
        else if (!busy[0]) take = BIT_P0;
      end
      default: begin
        if (!busy[2])      take = BIT_P5;
        else if (!busy[0]) take = BIT_P0;
        else if (!busy[1]) take = BIT_P1;
      end
    endcase
    return take;
  endfunction

endpackage

@@ design/epr_cell.sv @@
// One cell of the reservation chain: eight table rows and the scan token.
module epr_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [epr_pkg::CELL_W-1:0] idx,
  input  epr_pkg::cell_req_t      req,
  input  logic                    tok_in,
  output logic                    tok_out,
  output epr_pkg::cell_res_t      res
);
  import epr_pkg::*;

  logic [BUSY_W-1:0] rows [ROWS_PER_CELL];
  logic              tok;
  logic              first;
  logic              hit;
  logic [ROW_W-1:0]  hit_row;
  logic [BUSY_W-1:0] hit_take;

  always_comb begin
    logic [BUSY_W-1:0] take;
    logic              ok;
    hit      = 1'b0;
    hit_row  = '0;
    hit_take = '0;
    for (int r = ROWS_PER_CELL - 1; r >= 0; r--) begin
      take = row_pick(rows[r], req.first, req.second);
      ok   = tok && (take != '0) && (!first || (ROW_W'(r) >= req.lo))
             && ((int'(idx) * ROWS_PER_CELL + r) < LIMIT);
      if (ok) begin
        hit      = 1'b1;
        hit_row  = ROW_W'(r);
        hit_take = take;
      end
    end
  end

  assign tok_out   = tok && !hit;
  assign res.hit   = hit;
  assign res.cycle = hit ? CYC_W'({idx, hit_row}) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= 1'b0;
      first <= 1'b0;
    end else if (req.load) begin
      tok   <= (idx == req.start_cell);
      first <= (idx == req.start_cell);
    end else if (req.go) begin
      tok   <= tok_in;
      first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      for (int r = 0; r < ROWS_PER_CELL; r++) rows[r] <= '0;
    end else if (req.go && req.commit && hit) begin
      rows[hit_row] <= rows[hit_row] | hit_take;
    end
  end

endmodule

@@ design/execution_port_reservation_scheduler.sv @@
// Clear, no-op, eliminated and out-of-window requests use the quick state;
// the others use the scan state while the scan token walks the 8-row cells from the
// start cell up to the first hit or the last of the 32 cells. One request is in flight at a time.
// A new request waits until the last one is emitted, which an output stall delays.
// Reset clears the whole reservation table and all control state.
module execution_port_reservation_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [epr_pkg::FUNC_W-1:0]  func,
  input  logic [epr_pkg::CLASS_W-1:0] port_first,
  input  logic [epr_pkg::PORT_W-1:0]  port_second,
  input  logic                        dependent,
  input  logic [epr_pkg::CYC_W-1:0]   start_cycle,
  input  logic [epr_pkg::CYC_W-1:0]   dep_cycle,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [epr_pkg::CYC_W-1:0]   sched_cycle
);
  import epr_pkg::*;

  state_t             state, state_next;
  logic [FUNC_W-1:0]  req_func;
  logic [CLASS_W-1:0] req_first;
  logic [PORT_W-1:0]  req_second;
  logic [CYC_W-1:0]   req_cycle;

  logic [CYC_W-1:0]   eff_cycle;
  logic               accept;
  logic               quick;
  logic               slot_free;
  logic               emit;
  logic               emit_found;
  logic [CYC_W-1:0]   emit_cycle;
  logic               any_hit;
  logic [CYC_W-1:0]   hit_cycle;
  cell_req_t          creq;
  cell_res_t          cres [NCELL];
  logic [NCELL:0]     tok_link;

  assign eff_cycle = (dependent && dep_cycle > start_cycle) ? dep_cycle : start_cycle;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign quick     = (func == FN_CLEAR) || (func == FN_NOP) || (port_first == PC_NONE)
                     || (int'(eff_cycle) >= LIMIT);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    any_hit   = 1'b0;
    hit_cycle = '0;
    for (int c = 0; c < NCELL; c++) begin
      any_hit   = any_hit | cres[c].hit;
      hit_cycle = hit_cycle | cres[c].cycle;
    end
  end

  always_comb begin
    state_next      = state;
    emit            = 1'b0;
    emit_found      = 1'b0;
    emit_cycle      = '0;
    creq.load       = accept && !quick;
    creq.start_cell = CELL_W'(eff_cycle >> ROW_W);
    creq.go         = 1'b0;
    creq.commit     = (req_func == FN_RESERVE);
    creq.clear      = 1'b0;
    creq.lo         = req_cycle[ROW_W-1:0];
    creq.first      = req_first;
    creq.second     = req_second;
    case (state)
      S_IDLE: begin
        if (accept) state_next = quick ? S_QUICK : S_SCAN;
      end
      S_SCAN: begin
        creq.go = slot_free;
        if (slot_free && any_hit) begin
          emit       = 1'b1;
          emit_found = 1'b1;
          emit_cycle = hit_cycle;
          state_next = S_IDLE;
        end else if (slot_free && tok_link[NCELL]) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_QUICK: begin
        if (slot_free) begin
          emit       = 1'b1;
          creq.clear = (req_func == FN_CLEAR);
          if ((req_func == FN_PROBE || req_func == FN_RESERVE) && req_first == PC_NONE) begin
            emit_found = 1'b1;
            emit_cycle = req_cycle;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func   <= func;
      req_first  <= port_first;
      req_second <= port_second;
      req_cycle  <= eff_cycle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found       <= emit_found;
      sched_cycle <= emit_cycle;
    end
  end

  assign tok_link[0] = 1'b0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    epr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (CELL_W'(g)),
      .req     (creq),
      .tok_in  (tok_link[g]),
      .tok_out (tok_link[g+1]),
      .res     (cres[g])
    );
  end

endmodule

@@ tb/sv/execution_port_reservation_scheduler_checker.sv @@
// Checker for the port reservation scheduler: predicts each request's result and compares.
module execution_port_reservation_scheduler_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [epr_pkg::FUNC_W-1:0]    func,
  input  logic [epr_pkg::CLASS_W-1:0]   port_first,
  input  logic [epr_pkg::PORT_W-1:0]    port_second,
  input  logic                          dependent,
  input  logic [epr_pkg::CYC_W-1:0]     start_cycle,
  input  logic [epr_pkg::CYC_W-1:0]     dep_cycle,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          found,
  input  logic [epr_pkg::CYC_W-1:0]     sched_cycle,
  output int                            mismatch_count,
  output int                            slots_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import epr_pkg::*;

  typedef struct packed {
    logic             found;
    logic [CYC_W-1:0] cycle;
  } slot_result_t;

  logic [BUSY_W-1:0] port_table [WINDOW_CYCLES];
  slot_result_t      expected_slots [$];

  function automatic logic [BUSY_W-1:0] port_mask(input logic [PORT_W-1:0] p);
    logic [BUSY_W-1:0] m;
    m = '0;
    if (p != SP_NONE) m[p - 1] = 1'b1;
    return m;
  endfunction

  function automatic logic [BUSY_W-1:0] free_ports_pick(input logic [BUSY_W-1:0]  busy,
                                                        input logic [CLASS_W-1:0] cls,
                                                        input logic [PORT_W-1:0]  sec);
    logic [PORT_W-1:0] order [3];
    logic [BUSY_W-1:0] need;
    if (cls < PC_P01) begin
      need = port_mask(cls[PORT_W-1:0]) | port_mask(sec);
      return ((busy & need) == '0) ? need : '0;
    end
    case (cls)
      PC_P01:  order = '{SP_P0, SP_P1, SP_NONE};
      PC_P05:  order = '{SP_P5, SP_P0, SP_NONE};
      default: order = '{SP_P5, SP_P0, SP_P1};
    endcase
    for (int k = 0; k < 3; k++) begin
      if (order[k] != SP_NONE && (busy & port_mask(order[k])) == '0) return port_mask(order[k]);
    end
    return '0;
  endfunction

  task automatic schedule_request(input func_t f, input logic [CLASS_W-1:0] cls,
                                  input logic [PORT_W-1:0] sec, input logic dep,
                                  input logic [CYC_W-1:0] st, input logic [CYC_W-1:0] dc,
                                  output slot_result_t res);
    logic [CYC_W-1:0]  row;
    logic [BUSY_W-1:0] take;
    res = '0;
    case (f)
      FN_CLEAR: foreach (port_table[i]) port_table[i] = '0;
      FN_NOP: ;
      default: begin
        row = (dep && dc > st) ? dc : st;
        if (cls == PC_NONE) begin
          res.found = 1'b1;
          res.cycle = row;
        end else begin
          for (int i = int'(row); i < LIMIT && !res.found; i++) begin
            take = free_ports_pick(port_table[i], cls, sec);
            if (take != '0) begin
              if (f == FN_RESERVE) port_table[i] = port_table[i] | take;
              res.found = 1'b1;
              res.cycle = CYC_W'(i);
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    slot_result_t want;
    slot_result_t oldest;
    if (rst) begin
      foreach (port_table[i]) port_table[i] = '0;
      expected_slots.delete();
      mismatch_count = 0;
      slots_pending <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        schedule_request(func_t'(func), port_first, port_second, dependent,
                         start_cycle, dep_cycle, want);
        expected_slots.insert(expected_slots.size(), want);
      end
      if (out_valid && !out_stall) begin
        if (expected_slots.size() == 0) begin
          $error("unexpected result: found %0d sched_cycle %0d", found, sched_cycle);
          mismatch_count++;
        end else begin
          oldest = expected_slots.pop_front();
          if (found !== oldest.found) begin
            $error("found: expected %0d, actual %0d", oldest.found, found);
            mismatch_count++;
          end
          if (sched_cycle !== oldest.cycle) begin
            $error("sched_cycle: expected %0d, actual %0d", oldest.cycle, sched_cycle);
            mismatch_count++;
          end
        end
      end
      slots_pending <= expected_slots.size();
    end
  end

endmodule

@@ tb/sv/execution_port_reservation_scheduler_tb.sv @@
// Testbench top for the port reservation scheduler: clock, reset, stimulus and verdict.
module execution_port_reservation_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import epr_pkg::*;

  localparam int RANDOM_REQUESTS = 600;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 40;
  localparam logic [CLASS_W-1:0] CLASS_P015   = 3'd6;
  localparam logic [CLASS_W-1:0] CLASS_UNUSED = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = FN_NOP;
  logic [CLASS_W-1:0]  port_first = PC_NONE;
  logic [PORT_W-1:0]   port_second = SP_NONE;
  logic                dependent = 1'b0;
  logic [CYC_W-1:0]    start_cycle = '0;
  logic [CYC_W-1:0]    dep_cycle = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                found;
  logic [CYC_W-1:0]    sched_cycle;

  int mismatch_count;
  int slots_pending;
  int sent_count = 0;
  bit calm = 1'b0;
  int hold_left = 0;
  bit held = 1'b0;
  int quiet = 0;

  always #4 clk = ~clk;

  execution_port_reservation_scheduler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .port_first(port_first), .port_second(port_second),
    .dependent(dependent), .start_cycle(start_cycle), .dep_cycle(dep_cycle),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .sched_cycle(sched_cycle)
  );

  execution_port_reservation_scheduler_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .port_first(port_first), .port_second(port_second),
    .dependent(dependent), .start_cycle(start_cycle), .dep_cycle(dep_cycle),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .sched_cycle(sched_cycle),
    .mismatch_count(mismatch_count), .slots_pending(slots_pending)
  );

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && sent_count >= 320) begin
      held      <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 29);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("execution_port_reservation_scheduler_tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic issue(input func_t f, input logic [CLASS_W-1:0] cls,
                       input logic [PORT_W-1:0] sec, input logic dep,
                       input logic [CYC_W-1:0] st, input logic [CYC_W-1:0] dc);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    port_first  <= cls;
    port_second <= sec;
    dependent   <= dep;
    start_cycle <= st;
    dep_cycle   <= dc;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_count <= sent_count + 1;
  endtask

  initial begin
    func_t               f;
    logic [CLASS_W-1:0]  cls;
    logic [PORT_W-1:0]   sec;
    logic                dep;
    logic [CYC_W-1:0]    st;
    logic [CYC_W-1:0]    dc;
    int                  burst_left;
    int                  base;
    int                  roll;

    burst_left = 0;
    base = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    issue(FN_CLEAR,   PC_P0,        SP_P5,   1'b1, 9'd511, 9'd511);
    issue(FN_RESERVE, PC_P0,        SP_NONE, 1'b0, 9'd0,   9'd0);
    issue(FN_RESERVE, PC_P0,        SP_NONE, 1'b0, 9'd0,   9'd0);
    issue(FN_PROBE,   PC_P01,       SP_NONE, 1'b0, 9'd0,   9'd0);
    issue(FN_RESERVE, PC_P05,       SP_NONE, 1'b0, 9'd0,   9'd0);
    issue(FN_RESERVE, CLASS_P015,   SP_NONE, 1'b0, 9'd0,   9'd0);
    issue(FN_PROBE,   CLASS_P015,   SP_NONE, 1'b0, 9'd0,   9'd0);
    issue(FN_RESERVE, PC_P0,        SP_P5,   1'b0, 9'd0,   9'd0);
    issue(FN_RESERVE, PC_P1,        SP_P1,   1'b0, 9'd0,   9'd0);
    issue(FN_RESERVE, PC_P5,        SP_P0,   1'b1, 9'd0,   9'd2);
    issue(FN_RESERVE, PC_NONE,      SP_P1,   1'b1, 9'd5,   9'd500);
    issue(FN_PROBE,   PC_NONE,      SP_NONE, 1'b0, 9'd400, 9'd0);
    issue(FN_PROBE,   PC_P0,        SP_NONE, 1'b1, 9'd300, 9'd10);
    issue(FN_RESERVE, PC_P5,        SP_NONE, 1'b1, 9'd511, 9'd511);
    issue(FN_RESERVE, CLASS_UNUSED, SP_NONE, 1'b0, 9'd255, 9'd0);
    issue(FN_RESERVE, CLASS_UNUSED, SP_P0,   1'b0, 9'd255, 9'd0);
    issue(FN_RESERVE, CLASS_P015,   SP_P5,   1'b0, 9'd255, 9'd0);
    issue(FN_PROBE,   PC_P0,        SP_NONE, 1'b0, 9'd255, 9'd0);
    issue(FN_RESERVE, PC_P01,       SP_P5,   1'b0, 9'd254, 9'd0);
    issue(FN_NOP,     CLASS_UNUSED, SP_P5,   1'b1, 9'd511, 9'd511);
    issue(FN_PROBE,   PC_P1,        SP_NONE, 1'b0, 9'd3,   9'd511);
    issue(FN_CLEAR,   PC_NONE,      SP_NONE, 1'b0, 9'd0,   9'd0);
    issue(FN_PROBE,   PC_P0,        SP_NONE, 1'b0, 9'd0,   9'd0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm <= (n >= 150 && n < 260);
      if (n == 450) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (slots_pending != 0);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(3, 20);
        roll = $urandom_range(0, 9);
        if (roll < 6)      base = $urandom_range(0, 200);
        else if (roll < 9) base = $urandom_range(230, 255);
        else               base = $urandom_range(0, 511);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2)       f = FN_CLEAR;
      else if (roll < 4)  f = FN_NOP;
      else if (roll < 30) f = FN_PROBE;
      else                f = FN_RESERVE;
      roll = $urandom_range(0, 99);
      if (roll < 5)       cls = PC_NONE;
      else if (roll < 8)  cls = CLASS_UNUSED;
      else                cls = CLASS_W'($urandom_range(1, 6));
      sec = ($urandom_range(0, 1) == 0) ? SP_NONE : PORT_W'($urandom_range(0, 3));
      dep = 1'($urandom_range(0, 1));
      st  = CYC_W'(base + $urandom_range(0, 7));
      dc  = ($urandom_range(0, 3) == 0) ? CYC_W'($urandom_range(0, 511))
                                        : CYC_W'(st + $urandom_range(0, 12));
      issue(f, cls, sec, dep, st, dc);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (slots_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("execution_port_reservation_scheduler_tb: clean");
    end else begin
      $display("execution_port_reservation_scheduler_tb: errors");
    end
    $finish;
  end

endmodule
